// File: rtl/lir_pkg.sv
// Package for the linear interpolation resampler.
// Widths, position constants, command struct. No dependencies.
`timescale 1ns / 1ps

package lir_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 16;
  localparam int STEP_W      = 21;
  localparam int POS_W       = FRAC_BITS + 6;
  localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CLAMP_W     = (STEP_W > POS_W) ? STEP_W : POS_W;
  localparam int PROD_W      = SAMPLE_BITS + FRAC_BITS + 2;

  localparam logic [POS_W-1:0]   ONE_POS    = POS_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0]   TWO_POS    = POS_W'(1) << (FRAC_BITS + 1);
  localparam logic [CLAMP_W-1:0] STEP_MIN   = CLAMP_W'(1) << (FRAC_BITS - 4);
  localparam logic [CLAMP_W-1:0] STEP_MAX   = CLAMP_W'(1) << (FRAC_BITS + 4);
  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(65536);
  localparam logic [PROD_W-1:0]  HALF_LSB   = PROD_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [1:0] {
    HOLD_KEEP,
    HOLD_IN,
    HOLD_X
  } hold_sel_t;

  typedef struct packed {
    logic                 load_new;
    hold_sel_t            hold_sel;
    logic                 issue;
    logic [FRAC_BITS-1:0] frac;
    logic                 run_end;
    logic                 stream_end;
  } cmd_t;

endpackage

// File: rtl/lir_ctrl.sv
// Resampler controller: input handshake, step register, position sequencer.
// Drives lir_datapath through cmd_t; uses lir_pkg.
`timescale 1ns / 1ps

module lir_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [lir_pkg::STEP_W-1:0]   cfg_wr_data,
  input  logic                         in_tvalid,
  input  logic                         in_tlast,
  output logic                         in_tready,
  input  logic                         adv,
  output lir_pkg::cmd_t                cmd
);
  import lir_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INTERP,
    S_FLUSH
  } state_t;

  state_t               state_r, state_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [POS_W-1:0]     st_r, st_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic                 last_r, last_nxt;
  logic                 have_r, have_nxt;

  logic [CLAMP_W-1:0]   step_ext;
  logic [CLAMP_W-1:0]   step_cl;
  logic [POS_W-1:0]     pos_sum;
  logic                 in_go;

  assign in_tready = (state_r == S_IDLE);
  assign in_go     = in_tvalid && in_tready;
  assign pos_sum   = pos_r + st_r;

  always_comb begin
    step_ext = CLAMP_W'(step_r);
    if (step_ext < STEP_MIN) begin
      step_cl = STEP_MIN;
    end else if (step_ext > STEP_MAX) begin
      step_cl = STEP_MAX;
    end else begin
      step_cl = step_ext;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = cfg_wr_en ? cfg_wr_data : step_r;
    st_nxt    = st_r;
    pos_nxt   = pos_r;
    last_nxt  = last_r;
    have_nxt  = have_r;

    cmd            = '0;
    cmd.hold_sel   = HOLD_KEEP;
    cmd.frac       = pos_r[FRAC_BITS-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_go) begin
          cmd.load_new = 1'b1;
          st_nxt       = POS_W'(step_cl);
          last_nxt     = in_tlast;
          if (!have_r) begin
            cmd.hold_sel = HOLD_IN;
            have_nxt     = 1'b1;
            pos_nxt      = '0;
            state_nxt    = in_tlast ? S_FLUSH : S_IDLE;
          end else begin
            state_nxt = S_INTERP;
          end
        end
      end
      S_INTERP: begin
        if (pos_r >= ONE_POS) begin
          cmd.hold_sel = HOLD_X;
          pos_nxt      = pos_r - ONE_POS;
          state_nxt    = last_r ? S_FLUSH : S_IDLE;
        end else if (adv) begin
          cmd.issue      = 1'b1;
          cmd.run_end    = (pos_sum >= ONE_POS) && (!last_r || (pos_sum >= TWO_POS));
          cmd.stream_end = last_r && (pos_sum >= TWO_POS);
          pos_nxt        = pos_sum;
        end
      end
      S_FLUSH: begin
        if (pos_r >= ONE_POS) begin
          have_nxt  = 1'b0;
          pos_nxt   = '0;
          state_nxt = S_IDLE;
        end else if (adv) begin
          cmd.issue      = 1'b1;
          cmd.frac       = '0;
          cmd.run_end    = (pos_sum >= ONE_POS);
          cmd.stream_end = (pos_sum >= ONE_POS);
          pos_nxt        = pos_sum;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= STEP_RESET;
      st_r    <= '0;
      pos_r   <= '0;
      last_r  <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      st_r    <= st_nxt;
      pos_r   <= pos_nxt;
      last_r  <= last_nxt;
      have_r  <= have_nxt;
    end
  end

endmodule

// File: rtl/lir_datapath.sv
// Resampler datapath: sample registers, multiply stage, round/add stage, output register.
// Commanded by lir_ctrl through cmd_t; uses lir_pkg.
`timescale 1ns / 1ps

module lir_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lir_pkg::cmd_t                  cmd,
  input  logic [lir_pkg::SAMPLE_BITS-1:0] sample_in,
  output logic                           adv,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lir_pkg::SAMPLE_BITS-1:0] sample_out,
  output logic                           run_end,
  output logic                           stream_end
);
  import lir_pkg::*;

  logic signed [SAMPLE_BITS-1:0] x_r, held_r;
  logic signed [SAMPLE_BITS-1:0] base_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic                          s1_valid_r, s1_run_r, s1_stream_r;
  logic                          out_valid_r, out_run_r, out_stream_r;
  logic [SAMPLE_BITS-1:0]        out_data_r;

  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [PROD_W-1:0]      prod_nxt;
  logic signed [PROD_W-1:0]      rnd;
  logic signed [PROD_W-1:0]      shifted;
  logic signed [SAMPLE_BITS+1:0] sum;

  assign adv = !out_valid_r || out_tready;

  assign diff     = (SAMPLE_BITS+1)'(x_r) - (SAMPLE_BITS+1)'(held_r);
  assign prod_nxt = PROD_W'(diff) * $signed({{(PROD_W-FRAC_BITS){1'b0}}, cmd.frac});
  assign rnd      = prod_r + $signed(HALF_LSB);
  assign shifted  = rnd >>> FRAC_BITS;
  assign sum      = (SAMPLE_BITS+2)'(base_r) + shifted[SAMPLE_BITS+1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_new) begin
      x_r <= sample_in;
    end
    case (cmd.hold_sel)
      HOLD_IN:   held_r <= sample_in;
      HOLD_X:    held_r <= x_r;
      default:   held_r <= held_r;
    endcase
    if (adv) begin
      if (cmd.issue) begin
        prod_r      <= prod_nxt;
        base_r      <= held_r;
        s1_run_r    <= cmd.run_end;
        s1_stream_r <= cmd.stream_end;
      end
      if (s1_valid_r) begin
        out_data_r   <= sum[SAMPLE_BITS-1:0];
        out_run_r    <= s1_run_r;
        out_stream_r <= s1_stream_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= cmd.issue;
      out_valid_r <= s1_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign sample_out = out_data_r;
  assign run_end    = out_run_r;
  assign stream_end = out_stream_r;

endmodule

// File: rtl/linear_interp_resampler.sv
// Top level of the linear interpolation resampler for one channel.
// Instantiates lir_ctrl and lir_datapath; uses lir_pkg.
//
//   channel  direction  handshake                 payload
//   in_      slave      in_tvalid / in_tready     tdata: sample_in; tlast: stream_last
//   out_     master     out_tvalid / out_tready   tdata: sample_out; tlast: run_end;
//                                                 tuser: stream_end
//   cfg_     write      cfg_wr_en                 cfg_wr_data: step
//
// The position sequencer issues one result per cycle while the result path advances,
// into a two-stage multiply/round path: each input's results, a step onto the input,
// then after stream_last the flush results. Results pass the multiply register, then
// the output register. Reset is synchronous, active low; step resets to 1.0.
// out_tready low with a result waiting freezes the result path and issue; a new input
// is taken once the sequencer is idle, even while results are in flight or waiting.
`timescale 1ns / 1ps

module linear_interp_resampler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [lir_pkg::STEP_W-1:0]    cfg_wr_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lir_pkg::DATA_W-1:0]    in_tdata,   // sample_in
  input  logic                          in_tlast,   // stream_last
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lir_pkg::DATA_W-1:0]    out_tdata,  // sample_out
  output logic                          out_tlast,  // run_end
  output logic [0:0]                    out_tuser   // stream_end
);
  import lir_pkg::*;

  cmd_t                   cmd;
  logic                   adv;
  logic [SAMPLE_BITS-1:0] sample_out;
  logic                   stream_end;

  lir_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tlast    (in_tlast),
    .in_tready   (in_tready),
    .adv         (adv),
    .cmd         (cmd)
  );

  lir_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sample_in  (in_tdata[SAMPLE_BITS-1:0]),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sample_out (sample_out),
    .run_end    (out_tlast),
    .stream_end (stream_end)
  );

  assign out_tdata = DATA_W'(sample_out);
  assign out_tuser = stream_end;

endmodule
